// ----- rtl/irmu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Ising ring majority update block.
// No dependencies.
package irmu_pkg;

  localparam int MAX_SITES_DEF = 1024;
  localparam int MAX_RANGE_DEF = 16;

  localparam int REQ_W    = 2;
  localparam int SITE_W   = 10;
  localparam int CNT_W    = 11;
  localparam int MAG_W    = 12;
  localparam int AS_W     = 11;
  localparam int NR_W     = 5;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [AS_W-1:0] ACTIVE_SITES_RST   = 11'd1024;
  localparam logic [NR_W-1:0] NEIGHBOR_RANGE_RST = 5'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SITES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_RANGE = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_UPDATE  = 2'd1,
    REQ_MEASURE = 2'd2
  } req_t;

endpackage

// ----- rtl/ising_ring_majority_update.sv -----
`timescale 1ns / 1ps
// Top level: ring of spins with per-site persistence marks, zero-temperature update.
// Depends on irmu_pkg.

// After reset the block sweeps both site memories once (in_stall high, configuration
// writes still taken). It then handles one transaction at a time through a single
// read port and a shared spin-count accumulator under a small sequencer. A load, an
// out-of-range site or an unknown request goes straight to the output stage. An update
// reads its own site and then 2*w neighbors one per cycle, w the range in use. A measure
// reads the n active sites one per cycle. A finished result waits in an output register,
// so the next transaction may be accepted meanwhile.
module ising_ring_majority_update #(
  parameter int MAX_SITES = irmu_pkg::MAX_SITES_DEF,
  parameter int MAX_RANGE = irmu_pkg::MAX_RANGE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [irmu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [irmu_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [irmu_pkg::REQ_W-1:0]             in_req_type,
  input  logic [irmu_pkg::SITE_W-1:0]            in_site_index,
  input  logic                                   in_spin_value,
  input  logic                                   in_tie_coin,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_status,
  output logic                                   out_flipped,
  output logic                                   out_new_spin,
  output logic signed [irmu_pkg::MAG_W-1:0]      out_magnetization,
  output logic [irmu_pkg::CNT_W-1:0]             out_domain_walls,
  output logic [irmu_pkg::CNT_W-1:0]             out_persistent_sites
);
  import irmu_pkg::*;

  localparam int AW  = $clog2(MAX_SITES);
  localparam int NW  = AW + 1;
  localparam int RW  = $clog2(MAX_RANGE + 1);
  localparam int CTW = $clog2(2 * MAX_RANGE);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_UPD   = 9'b000000100,
    S_UFIN  = 9'b000001000,
    S_UDEC  = 9'b000010000,
    S_MEAS  = 9'b000100000,
    S_MFIN  = 9'b001000000,
    S_MEND  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AS_W-1:0]  as_r;
  logic [NR_W-1:0]  nr_r;
  logic [NW-1:0]    n_use;
  logic [RW-1:0]    w_use;

  logic [AW-1:0]    ptr_r, ptr_nxt, lptr_r, lptr_nxt;
  logic [AW-1:0]    site_r, site_nxt;
  logic [CTW-1:0]   cnt_r, cnt_nxt;
  logic             coin_r, coin_nxt;
  logic             spin_r, spin_nxt;
  logic             prev_r, prev_nxt, first_r, first_nxt;
  logic [CNT_W-1:0] ups_r, ups_nxt, keep_r, keep_nxt, walls_r, walls_nxt;

  logic             rd_self_r, rd_self_nxt, rd_nb_r, rd_nb_nxt;
  logic             rd_ms_r, rd_ms_nxt, rd_first_r, rd_first_nxt;

  logic             res_status_r, res_status_nxt, res_flipped_r, res_flipped_nxt;
  logic             res_spin_r, res_spin_nxt;
  logic [MAG_W-1:0] res_mag_r, res_mag_nxt;
  logic [CNT_W-1:0] res_walls_r, res_walls_nxt, res_keep_r, res_keep_nxt;

  logic             out_valid_r, out_valid_nxt, out_load;

  logic             spin_mem [MAX_SITES];
  logic             mark_mem [MAX_SITES];
  logic             rd_spin_r, rd_mark_r;
  logic             rd_en, spin_we, mark_we, spin_wd, mark_wd;
  logic [AW-1:0]    rd_addr, wr_addr;

  logic [NW-1:0]    ptr_inc;
  logic [AW-1:0]    ptr_next, lptr_prev, last_site;
  logic [CTW-1:0]   nb_last;
  logic             flip;

  // ring size and range in use
  always_comb begin
    if (as_r < AS_W'(2)) begin
      n_use = NW'(2);
    end else if (32'(as_r) > MAX_SITES) begin
      n_use = NW'(MAX_SITES);
    end else begin
      n_use = NW'(as_r);
    end
    if (nr_r == '0) begin
      w_use = RW'(1);
    end else if (32'(nr_r) > MAX_RANGE) begin
      w_use = RW'(MAX_RANGE);
    end else begin
      w_use = RW'(nr_r);
    end
  end

  assign ptr_inc   = {1'b0, ptr_r} + NW'(1);
  assign last_site = AW'(n_use - NW'(1));
  assign ptr_next  = (ptr_inc == n_use) ? '0 : ptr_inc[AW-1:0];
  assign lptr_prev = (lptr_r == '0) ? last_site : lptr_r - AW'(1);
  assign nb_last   = CTW'((RW + 1)'({w_use, 1'b0}) - (RW + 1)'(1));

  assign flip = spin_r ? ((ups_r < CNT_W'(w_use)) || ((ups_r == CNT_W'(w_use)) && coin_r))
                       : ((ups_r > CNT_W'(w_use)) || ((ups_r == CNT_W'(w_use)) && coin_r));

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    lptr_nxt        = lptr_r;
    site_nxt        = site_r;
    cnt_nxt         = cnt_r;
    coin_nxt        = coin_r;
    spin_nxt        = spin_r;
    prev_nxt        = prev_r;
    first_nxt       = first_r;
    ups_nxt         = ups_r;
    keep_nxt        = keep_r;
    walls_nxt       = walls_r;
    rd_self_nxt     = 1'b0;
    rd_nb_nxt       = 1'b0;
    rd_ms_nxt       = 1'b0;
    rd_first_nxt    = 1'b0;
    res_status_nxt  = res_status_r;
    res_flipped_nxt = res_flipped_r;
    res_spin_nxt    = res_spin_r;
    res_mag_nxt     = res_mag_r;
    res_walls_nxt   = res_walls_r;
    res_keep_nxt    = res_keep_r;
    rd_en           = 1'b0;
    rd_addr         = ptr_r;
    spin_we         = 1'b0;
    mark_we         = 1'b0;
    spin_wd         = 1'b0;
    mark_wd         = 1'b0;
    wr_addr         = ptr_r;
    out_load        = 1'b0;

    // returning read data
    if (rd_self_r) begin
      spin_nxt = rd_spin_r;
    end
    if (rd_nb_r) begin
      ups_nxt = ups_r + CNT_W'(rd_spin_r);
    end
    if (rd_ms_r) begin
      ups_nxt  = ups_r + CNT_W'(rd_spin_r);
      keep_nxt = keep_r + CNT_W'(rd_mark_r);
      prev_nxt = rd_spin_r;
      if (rd_first_r) begin
        first_nxt = rd_spin_r;
      end else begin
        walls_nxt = walls_r + CNT_W'(rd_spin_r != prev_r);
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        spin_we = 1'b1;
        mark_we = 1'b1;
        spin_wd = 1'b0;
        mark_wd = 1'b1;
        wr_addr = ptr_r;
        ptr_nxt = ptr_r + AW'(1);
        if (32'(ptr_r) == MAX_SITES - 1) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt  = 1'b0;
          res_flipped_nxt = 1'b0;
          res_spin_nxt    = 1'b0;
          res_mag_nxt     = '0;
          res_walls_nxt   = '0;
          res_keep_nxt    = '0;
          priority if ((in_req_type == REQ_LOAD || in_req_type == REQ_UPDATE) &&
                       (32'(in_site_index) >= 32'(n_use))) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_OUT;
          end else if (in_req_type == REQ_LOAD) begin
            spin_we      = 1'b1;
            spin_wd      = in_spin_value;
            wr_addr      = AW'(in_site_index);
            res_spin_nxt = in_spin_value;
            state_nxt    = S_OUT;
          end else if (in_req_type == REQ_UPDATE) begin
            rd_en       = 1'b1;
            rd_addr     = AW'(in_site_index);
            rd_self_nxt = 1'b1;
            site_nxt    = AW'(in_site_index);
            ptr_nxt     = AW'(in_site_index);
            lptr_nxt    = AW'(in_site_index);
            coin_nxt    = in_tie_coin;
            cnt_nxt     = '0;
            ups_nxt     = '0;
            state_nxt   = S_UPD;
          end else if (in_req_type == REQ_MEASURE) begin
            ptr_nxt   = '0;
            ups_nxt   = '0;
            keep_nxt  = '0;
            walls_nxt = '0;
            state_nxt = S_MEAS;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_UPD: begin
        rd_en     = 1'b1;
        rd_nb_nxt = 1'b1;
        if (!cnt_r[0]) begin
          rd_addr = ptr_next;
          ptr_nxt = ptr_next;
        end else begin
          rd_addr  = lptr_prev;
          lptr_nxt = lptr_prev;
        end
        cnt_nxt = cnt_r + CTW'(1);
        if (cnt_r == nb_last) begin
          state_nxt = S_UFIN;
        end
      end
      S_UFIN: begin
        state_nxt = S_UDEC;
      end
      S_UDEC: begin
        if (flip) begin
          spin_we = 1'b1;
          mark_we = 1'b1;
          spin_wd = !spin_r;
          mark_wd = 1'b0;
        end
        wr_addr         = site_r;
        res_flipped_nxt = flip;
        res_spin_nxt    = spin_r ^ flip;
        state_nxt       = S_OUT;
      end
      S_MEAS: begin
        rd_en        = 1'b1;
        rd_addr      = ptr_r;
        rd_ms_nxt    = 1'b1;
        rd_first_nxt = (ptr_r == '0);
        ptr_nxt      = ptr_next;
        if (ptr_r == last_site) begin
          state_nxt = S_MFIN;
        end
      end
      S_MFIN: begin
        state_nxt = S_MEND;
      end
      S_MEND: begin
        res_mag_nxt   = MAG_W'({ups_r, 1'b0}) - MAG_W'(n_use);
        res_walls_nxt = walls_r + CNT_W'(prev_r != first_r);
        res_keep_nxt  = keep_r;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (spin_we) begin
      spin_mem[wr_addr] <= spin_wd;
    end
    if (mark_we) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    if (rd_en) begin
      rd_spin_r <= spin_mem[rd_addr];
      rd_mark_r <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      cnt_r       <= '0;
      rd_self_r   <= 1'b0;
      rd_nb_r     <= 1'b0;
      rd_ms_r     <= 1'b0;
      rd_first_r  <= 1'b0;
      out_valid_r <= 1'b0;
      as_r        <= ACTIVE_SITES_RST;
      nr_r        <= NEIGHBOR_RANGE_RST;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      rd_self_r   <= rd_self_nxt;
      rd_nb_r     <= rd_nb_nxt;
      rd_ms_r     <= rd_ms_nxt;
      rd_first_r  <= rd_first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_ACTIVE_SITES) begin
        as_r <= cfg_data[AS_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_NEIGHBOR_RANGE) begin
        nr_r <= cfg_data[NR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    lptr_r        <= lptr_nxt;
    site_r        <= site_nxt;
    coin_r        <= coin_nxt;
    spin_r        <= spin_nxt;
    prev_r        <= prev_nxt;
    first_r       <= first_nxt;
    ups_r         <= ups_nxt;
    keep_r        <= keep_nxt;
    walls_r       <= walls_nxt;
    res_status_r  <= res_status_nxt;
    res_flipped_r <= res_flipped_nxt;
    res_spin_r    <= res_spin_nxt;
    res_mag_r     <= res_mag_nxt;
    res_walls_r   <= res_walls_nxt;
    res_keep_r    <= res_keep_nxt;
    if (out_load) begin
      out_status           <= res_status_r;
      out_flipped          <= res_flipped_r;
      out_new_spin         <= res_spin_r;
      out_magnetization    <= $signed(res_mag_r);
      out_domain_walls     <= res_walls_r;
      out_persistent_sites <= res_keep_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/irmu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for ising_ring_majority_update, with its bind statement.
// Depends on irmu_pkg and the top level.
module irmu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_status,
  input logic                              out_flipped,
  input logic                              out_new_spin,
  input logic signed [irmu_pkg::MAG_W-1:0] out_magnetization,
  input logic [irmu_pkg::CNT_W-1:0]        out_domain_walls,
  input logic [irmu_pkg::CNT_W-1:0]        out_persistent_sites
);
  import irmu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_spin) &&
      $stable(out_magnetization) && $stable(out_domain_walls))
    else $error("stalled result changed");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_flipped && !out_new_spin &&
      out_magnetization == '0 && out_domain_walls == '0 && out_persistent_sites == '0)
    else $error("error result carries data");

  a_flip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flipped |-> !out_status && out_magnetization == '0 &&
      out_domain_walls == '0 && out_persistent_sites == '0)
    else $error("update result carries measure data");

  a_walls_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_domain_walls[0])
    else $error("odd domain wall count on a ring");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("activity right after reset");

endmodule

bind ising_ring_majority_update irmu_checker u_irmu_checker (.*);

// ----- tb/ising_ring_majority_update_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ising_ring_majority_update: directed table, then random phases
// under varying ring size and neighbor range, checked against a local spin-ring predictor.
// Depends on irmu_pkg and the ising_ring_majority_update RTL.
module ising_ring_majority_update_tb;
  import irmu_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int SITES = MAX_SITES_DEF;

  typedef struct packed {
    logic                    status;
    logic                    flipped;
    logic                    new_spin;
    logic signed [MAG_W-1:0] mag;
    logic [CNT_W-1:0]        walls;
    logic [CNT_W-1:0]        pers;
  } ring_result_t;

  typedef enum logic [1:0] {
    ROW_SEND,
    ROW_SET_SITES,
    ROW_SET_RANGE
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [REQ_W-1:0]  req;
    logic [SITE_W-1:0] site;
    logic              spin;
    logic              coin;
    logic [CFG_W-1:0]  value;
    bit                typed;
    ring_result_t      want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic [SITE_W-1:0]       in_site_index = '0;
  logic                    in_spin_value = 1'b0;
  logic                    in_tie_coin = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_status;
  logic                    out_flipped;
  logic                    out_new_spin;
  logic signed [MAG_W-1:0] out_magnetization;
  logic [CNT_W-1:0]        out_domain_walls;
  logic [CNT_W-1:0]        out_persistent_sites;

  ising_ring_majority_update dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_site_index        (in_site_index),
    .in_spin_value        (in_spin_value),
    .in_tie_coin          (in_tie_coin),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_flipped          (out_flipped),
    .out_new_spin         (out_new_spin),
    .out_magnetization    (out_magnetization),
    .out_domain_walls     (out_domain_walls),
    .out_persistent_sites (out_persistent_sites)
  );

  // predictor state
  logic            spins [0:SITES-1];
  logic            unflipped [0:SITES-1];
  logic [AS_W-1:0] sites_reg = ACTIVE_SITES_RST;
  logic [NR_W-1:0] range_reg = NEIGHBOR_RANGE_RST;

  ring_result_t pending_results [$];
  int           mismatch_count = 0;
  bit           hold_off_go = 1'b0;
  bit           hold_off_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int ring_span();
    int n;
    n = sites_reg;
    if (n < 2) n = 2;
    if (n > SITES) n = SITES;
    return n;
  endfunction

  function automatic ring_result_t glauber_step(logic [REQ_W-1:0] req, logic [SITE_W-1:0] site,
                                                logic spin, logic coin);
    ring_result_t r;
    int n, w, s, field, idx, right, left, ups, walls, keep;
    r = '0;
    n = ring_span();
    w = range_reg;
    if (w < 1) w = 1;
    if (w > MAX_RANGE_DEF) w = MAX_RANGE_DEF;
    idx = site;
    if (req == REQ_LOAD || req == REQ_UPDATE) begin
      if (idx >= n) begin
        r.status = 1'b1;
        return r;
      end
      if (req == REQ_LOAD) begin
        spins[idx] = spin;
      end else begin
        field = 0;
        s = spins[idx] ? 1 : -1;
        for (int j = 1; j <= w; j++) begin
          right = (idx + j) % n;
          left = (idx + (n - (j % n))) % n;
          field += spins[right] ? 1 : -1;
          field += spins[left] ? 1 : -1;
        end
        if (field * s < 0 || (field == 0 && coin)) begin
          spins[idx] = ~spins[idx];
          unflipped[idx] = 1'b0;
          r.flipped = 1'b1;
        end
      end
      r.new_spin = spins[idx];
    end else if (req == REQ_MEASURE) begin
      ups = 0;
      walls = 0;
      keep = 0;
      for (int i = 0; i < n; i++) begin
        ups += spins[i];
        walls += (spins[i] != spins[(i + 1 == n) ? 0 : i + 1]) ? 1 : 0;
        keep += unflipped[i];
      end
      r.mag = MAG_W'(2 * ups - n);
      r.walls = CNT_W'(walls);
      r.pers = CNT_W'(keep);
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0b, want %0b", out_status, want.status));
        if (out_flipped !== want.flipped)
          note_mismatch($sformatf("flipped %0b, want %0b", out_flipped, want.flipped));
        if (out_new_spin !== want.new_spin)
          note_mismatch($sformatf("new_spin %0b, want %0b", out_new_spin, want.new_spin));
        if (out_magnetization !== want.mag)
          note_mismatch($sformatf("magnetization %0d, want %0d", out_magnetization, want.mag));
        if (out_domain_walls !== want.walls)
          note_mismatch($sformatf("domain_walls %0d, want %0d", out_domain_walls, want.walls));
        if (out_persistent_sites !== want.pers)
          note_mismatch($sformatf("persistent_sites %0d, want %0d",
                                  out_persistent_sites, want.pers));
      end
    end
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin
    int mode, len, pct;
    forever begin
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(4, 40);
        pct = (mode == 0) ? 0 : (mode == 1) ? 25 : (mode == 2) ? 60 : 90;
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic offer(logic [REQ_W-1:0] req, logic [SITE_W-1:0] site, logic spin, logic coin,
                       bit typed, ring_result_t want);
    ring_result_t got;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_site_index <= site;
    in_spin_value <= spin;
    in_tie_coin <= coin;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = glauber_step(req, site, spin, coin);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_ACTIVE_SITES) sites_reg = data[AS_W-1:0];
    else range_reg = data[NR_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic plan_row_t mk_item(logic [REQ_W-1:0] req, int site, logic spin, logic coin);
    plan_row_t p;
    p.kind = ROW_SEND;
    p.req = req;
    p.site = SITE_W'(site);
    p.spin = spin;
    p.coin = coin;
    p.value = '0;
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t mk_typed(logic [REQ_W-1:0] req, int site, logic spin, logic coin,
                                         logic status, logic new_spin, int mag, int walls,
                                         int pers);
    plan_row_t p;
    p = mk_item(req, site, spin, coin);
    p.typed = 1'b1;
    p.want.status = status;
    p.want.new_spin = new_spin;
    p.want.mag = MAG_W'(mag);
    p.want.walls = CNT_W'(walls);
    p.want.pers = CNT_W'(pers);
    return p;
  endfunction

  function automatic plan_row_t mk_cfg(row_kind_t kind, int value);
    plan_row_t p;
    p = mk_item(REQ_LOAD, 0, 1'b0, 1'b0);
    p.kind = kind;
    p.value = CFG_W'(value);
    return p;
  endfunction

  initial begin
    plan_row_t        plan [$];
    plan_row_t        row;
    logic [REQ_W-1:0] req;
    logic [SITE_W-1:0] site;
    logic [CFG_W-1:0] value;
    int n, roll, meas_pct, burst_left, gap;

    for (int i = 0; i < SITES; i++) begin
      spins[i] = 1'b0;
      unflipped[i] = 1'b1;
    end

    // default ring: 1024 sites, one neighbor each side
    plan.push_back(mk_typed(REQ_MEASURE, 0, 1'b0, 1'b0, 1'b0, 1'b0, -1024, 0, 1024));
    plan.push_back(mk_typed(REQ_LOAD, 1023, 1'b1, 1'b0, 1'b0, 1'b1, 0, 0, 0));
    plan.push_back(mk_typed(REQ_LOAD, 0, 1'b1, 1'b0, 1'b0, 1'b1, 0, 0, 0));
    plan.push_back(mk_item(REQ_UPDATE, 1023, 1'b0, 1'b0));
    plan.push_back(mk_item(REQ_UPDATE, 1023, 1'b0, 1'b1));
    plan.push_back(mk_item(REQ_UPDATE, 512, 1'b1, 1'b1));
    plan.push_back(mk_typed(REQ_UNKNOWN, 1023, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0, 0));
    plan.push_back(mk_item(REQ_MEASURE, 1023, 1'b1, 1'b1));
    // ring size and range both saturated: two sites, range wraps past the ring
    plan.push_back(mk_cfg(ROW_SET_SITES, 0));
    plan.push_back(mk_cfg(ROW_SET_RANGE, 31));
    plan.push_back(mk_typed(REQ_LOAD, 2, 1'b1, 1'b0, 1'b1, 1'b0, 0, 0, 0));
    plan.push_back(mk_typed(REQ_UPDATE, 1023, 1'b1, 1'b1, 1'b1, 1'b0, 0, 0, 0));
    plan.push_back(mk_item(REQ_LOAD, 1, 1'b1, 1'b0));
    plan.push_back(mk_item(REQ_UPDATE, 0, 1'b0, 1'b0));
    plan.push_back(mk_item(REQ_UPDATE, 1, 1'b0, 1'b1));
    plan.push_back(mk_item(REQ_MEASURE, 0, 1'b0, 1'b0));
    // oversized ring clamps to 1024, zero range clamps to 1
    plan.push_back(mk_cfg(ROW_SET_SITES, 2047));
    plan.push_back(mk_cfg(ROW_SET_RANGE, 0));
    plan.push_back(mk_item(REQ_UPDATE, 0, 1'b0, 1'b1));
    plan.push_back(mk_typed(REQ_LOAD, 1023, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 0));
    plan.push_back(mk_item(REQ_MEASURE, 0, 1'b0, 1'b0));
    // five sites, range not below half the ring
    plan.push_back(mk_cfg(ROW_SET_SITES, 5));
    plan.push_back(mk_cfg(ROW_SET_RANGE, 3));
    plan.push_back(mk_item(REQ_LOAD, 4, 1'b1, 1'b0));
    plan.push_back(mk_item(REQ_UPDATE, 2, 1'b0, 1'b1));
    plan.push_back(mk_item(REQ_UPDATE, 0, 1'b1, 1'b0));
    plan.push_back(mk_typed(REQ_LOAD, 5, 1'b1, 1'b0, 1'b1, 1'b0, 0, 0, 0));
    plan.push_back(mk_item(REQ_MEASURE, 0, 1'b0, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_SEND) begin
        offer(row.req, row.site, row.spin, row.coin, row.typed, row.want);
      end else begin
        drain_results();
        write_reg(row.kind == ROW_SET_SITES ? CFG_ACTIVE_SITES : CFG_NEIGHBOR_RANGE, row.value);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 60) value = CFG_W'($urandom_range(2, 40));
      else if (roll < 80) value = CFG_W'($urandom_range(41, 400));
      else if (roll < 88) value = CFG_W'($urandom_range(0, 1));
      else if (roll < 96) value = CFG_W'(SITES);
      else value = CFG_W'($urandom_range(SITES + 1, 2047));
      write_reg(CFG_ACTIVE_SITES, value);
      roll = $urandom_range(0, 99);
      if (roll < 15) value = '0;
      else if (roll < 30) value = CFG_W'($urandom_range(MAX_RANGE_DEF, 31));
      else value = CFG_W'($urandom_range(1, MAX_RANGE_DEF - 1));
      if ($urandom_range(0, 1)) value[CFG_W-1:NR_W] = (CFG_W - NR_W)'($urandom);
      write_reg(CFG_NEIGHBOR_RANGE, value);

      // first phase: long receiver hold-off while items keep coming
      if (ph == 0) hold_off_go = 1'b1;
      n = ring_span();
      meas_pct = (n > 400) ? 2 : 8;
      burst_left = 0;
      for (int k = 0; k < 160; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) req = REQ_UNKNOWN;
        else if (roll < 3 + meas_pct) req = REQ_MEASURE;
        else if (roll < 35) req = REQ_LOAD;
        else req = REQ_UPDATE;
        site = SITE_W'($urandom_range(0, n - 1));
        if (n < SITES && $urandom_range(0, 99) < 8) site = SITE_W'($urandom_range(n, SITES - 1));
        if (req == REQ_UNKNOWN || req == REQ_MEASURE) site = SITE_W'($urandom_range(0, SITES - 1));
        offer(req, site, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        if (!(ph == 0 && k < 40)) begin
          gap = 0;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
          burst_left--;
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- ising_ring_majority_update.f -----
rtl/irmu_pkg.sv
rtl/ising_ring_majority_update.sv
rtl/irmu_checker.sv
tb/ising_ring_majority_update_tb.sv
